>>> rtl/lbgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life block step package
// Shared types and mask constants for the 4x2 block Life generation step.
// ----------------------------------------------------------------------------
package lbgs_pkg;

    localparam int unsigned BLOCK_W  = 8;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned WINDOW_W = 24;
    localparam int unsigned NUM_CELL = 8;

    typedef logic [BLOCK_W-1:0]         t_block;
    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic [WINDOW_W-1:0]        t_window;

    // Position of each next-generation cell within the window.
    localparam t_window C_CELL_MASK [NUM_CELL] = '{
        24'h000008, 24'h000040, 24'h000200, 24'h010000,
        24'h000800, 24'h040000, 24'h002000, 24'h100000
    };

    // The eight neighbours of each next-generation cell within the window.
    localparam t_window C_NBR_MASK [NUM_CELL] = '{
        24'h010357, 24'h0302BA, 24'h050D4C, 24'h0E0AC8,
        24'h153700, 24'h3B2A00, 24'h54DC00, 24'hECA800
    };

    // The new block sits three columns to the left of the incoming column.
    localparam t_coord C_X_OFFSET = 16'sd3;

endpackage

>>> rtl/lbgs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life block step channels
// Valid/ready channels for incoming column beats and outgoing result beats.
// ----------------------------------------------------------------------------
interface lbgs_in_if;
    import lbgs_pkg::*;

    logic   valid;
    logic   ready;
    t_block upper_block;
    t_block lower_block;
    t_coord column_x;
    logic   run_start;

    modport source (output valid, output upper_block, output lower_block,
                    output column_x, output run_start, input ready);
    modport sink   (input valid, input upper_block, input lower_block,
                    input column_x, input run_start, output ready);
endinterface

interface lbgs_out_if;
    import lbgs_pkg::*;

    logic   valid;
    logic   ready;
    t_block new_block;
    t_coord new_x;

    modport source (output valid, output new_block, output new_x, input ready);
    modport sink   (input valid, input new_block, input new_x, output ready);
endinterface

>>> rtl/lbgs_rule.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life block step rule logic
// Applies B3/S23 to the eight cells of a 24-bit neighborhood window.
// ----------------------------------------------------------------------------
module lbgs_rule (
    input  lbgs_pkg::t_window i_window,
    output lbgs_pkg::t_block  o_block
);
    import lbgs_pkg::*;

    // Neighbor count of one cell; at most eight bits are ever set.
    function automatic logic [3:0] f_count(input t_window v);
        logic [3:0] n;
        n = 4'd0;
        for (int b = 0; b < WINDOW_W; b++) begin
            n = n + {3'd0, v[b]};
        end
        return n;
    endfunction

    always_comb begin
        logic [3:0] cnt;
        logic       alive;
        o_block = '0;
        for (int k = 0; k < NUM_CELL; k++) begin
            cnt   = f_count(i_window & C_NBR_MASK[k]);
            alive = |(i_window & C_CELL_MASK[k]);
            o_block[k] = (cnt == 4'd3) || (alive && (cnt == 4'd2));
        end
    end

endmodule

>>> rtl/life_block_generation_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life block generation step core
// Streaming B3/S23 step over interleaved 4x2 cell blocks, one column a beat.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one column beat: the upper and lower row-pair bytes, the
//   column x coordinate and a run-start flag. The core keeps the previous
//   column's bytes and joins them with the top nibbles of the new column into
//   a 24-bit window. Run start uses zeros in place of the held column, and
//   the feeder closes each run with one all-zero column to flush it out.
//   o_out carries the next-generation block and its x (column_x - 3). Only
//   non-zero blocks produce an output beat; zero blocks are dropped.
// Timing:
//   Two register stages: the window register captured at acceptance and the
//   output register. Each result goes from the window stage to the output
//   stage; the core accepts one column every cycle while the output flows.
// Reset and stall:
//   Reset (synchronous, active low) empties both stages and clears the held
//   column. When the receiver stalls, the output holds its beat, the window
//   stage still fills behind it, and i_in.ready drops only when both stages
//   are occupied.
// ----------------------------------------------------------------------------
module life_block_generation_step_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lbgs_in_if.sink       i_in,
    lbgs_out_if.source    o_out
);
    import lbgs_pkg::*;

    // Held column from the previous beat.
    t_block  r_held_upper, n_held_upper;
    t_block  r_held_lower, n_held_lower;

    // Window stage.
    logic    r_win_valid, n_win_valid;
    t_window r_win,       n_win;
    t_coord  r_win_x,     n_win_x;

    // Output stage.
    logic    r_out_valid, n_out_valid;
    t_block  r_out_block, n_out_block;
    t_coord  r_out_x,     n_out_x;

    logic    in_take;
    logic    win_advance;
    t_block  rule_block;

    // The window stage moves on whenever the output register is free or is
    // being emptied this cycle.
    assign win_advance = !r_out_valid || o_out.ready;
    assign i_in.ready  = !r_win_valid || win_advance;
    assign in_take     = i_in.valid && i_in.ready;

    lbgs_rule u_rule (
        .i_window (r_win),
        .o_block  (rule_block)
    );

    always_comb begin
        t_block left_upper;
        t_block left_lower;

        n_held_upper = r_held_upper;
        n_held_lower = r_held_lower;
        n_win_valid  = r_win_valid;
        n_win        = r_win;
        n_win_x      = r_win_x;
        n_out_valid  = r_out_valid;
        n_out_block  = r_out_block;
        n_out_x      = r_out_x;

        // A run start means empty space to the left of this column.
        left_upper = i_in.run_start ? '0 : r_held_upper;
        left_lower = i_in.run_start ? '0 : r_held_lower;

        if (win_advance) begin
            n_win_valid = 1'b0;
            // Only live blocks become output beats.
            n_out_valid = r_win_valid && (rule_block != '0);
            n_out_block = rule_block;
            n_out_x     = r_win_x - C_X_OFFSET;
        end

        if (in_take) begin
            n_win_valid  = 1'b1;
            n_win        = {left_upper, left_lower,
                            i_in.upper_block[7:4], i_in.lower_block[7:4]};
            n_win_x      = i_in.column_x;
            // The whole bytes carry over, low nibbles included.
            n_held_upper = i_in.upper_block;
            n_held_lower = i_in.lower_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_upper <= '0;
            r_held_lower <= '0;
            r_win_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_held_upper <= n_held_upper;
            r_held_lower <= n_held_lower;
            r_win_valid  <= n_win_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win       <= n_win;
        r_win_x     <= n_win_x;
        r_out_block <= n_out_block;
        r_out_x     <= n_out_x;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.new_block = r_out_block;
    assign o_out.new_x     = r_out_x;

endmodule
